@@ hdl/fractal_gradient_noise_2d_defines.svh @@
// Assertion macros shared by the fractal gradient noise block.
// No dependencies; include with the bare file name.
`ifndef FRACTAL_GRADIENT_NOISE_2D_DEFINES_SVH
`define FRACTAL_GRADIENT_NOISE_2D_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FGN_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fgn: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define FGN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fgn: next-cycle check failed");

`endif

@@ hdl/fgn_pkg.sv @@
// Shared types, constants and the gradient tables of the fractal noise block.
// No dependencies.
`timescale 1ns / 1ps

package fgn_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int FRAC_BITS   = 16;
  localparam int ANGLE_BITS  = 10;

  localparam int OCT_W      = $clog2(MAX_OCTAVES);
  localparam int CNT_W      = 4;
  localparam int PERS_W     = 16;
  localparam int FREQ_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int COORD_W    = 32;
  localparam int NOISE_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQUENCY = 2'd2;

  localparam logic [CNT_W-1:0]  OCTAVE_COUNT_RST   = 4'd4;
  localparam logic [PERS_W-1:0] PERSISTENCE_RST    = 16'd16384;
  localparam logic [FREQ_W-1:0] BASE_FREQUENCY_RST = 24'd65536;

  // Multiply/rotate corner hash
  localparam logic [31:0] HASH_C1 = 32'd3284157443;
  localparam logic [31:0] HASH_C2 = 32'd1911520717;
  localparam logic [31:0] HASH_C3 = 32'd2048419325;

  // Datapath widths
  localparam int PROD_W      = COORD_W + FREQ_W + 1;
  localparam int SCALE_SHIFT = 32 - FRAC_BITS;
  localparam int TAB_W       = ANGLE_BITS - 2;
  localparam int TAB_DEPTH   = 1 << TAB_W;
  localparam int TRIG_W      = FRAC_BITS + 1;
  localparam int GRAD_W      = FRAC_BITS + 2;
  localparam int DOT_W       = FRAC_BITS + 5;
  localparam int FADE_W      = FRAC_BITS + 6;
  localparam int AMP_W       = 15 + MAX_OCTAVES;
  localparam int ASUM_W      = AMP_W + 1;
  localparam int TOT_W       = ASUM_W + FRAC_BITS + 1;
  localparam int QUO_W       = FRAC_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(QUO_W);

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SCALE,
    OP_HASH1,
    OP_HASH2,
    OP_HASH3,
    OP_GRAD,
    OP_DOT,
    OP_BLEND1,
    OP_BLEND2,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_HASH1,
    ST_HASH2,
    ST_HASH3,
    ST_GRAD,
    ST_DOT,
    ST_BLEND1,
    ST_BLEND2,
    ST_ACCUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    dp_op_t           op;
    logic [OCT_W-1:0] octave;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

  typedef logic [TRIG_W-1:0] trig_tab_t [TAB_DEPTH];

  // Quarter-turn sine/cosine by Taylor series in Q2.30, rounded to FRAC_BITS.
  function automatic trig_tab_t build_trig(input bit want_sin);
    trig_tab_t tab;
    longint    t, t2, s, c, term;
    for (int r = 0; r < TAB_DEPTH; r++) begin
      t  = (longint'(r) * 64'sd1686629713) >>> TAB_W;
      t2 = (t * t) >>> 30;
      s = t;
      term = ((term * 0) + t);
      term = ((term * t2) >>> 30) / 6;   s = s - term;
      term = ((term * t2) >>> 30) / 20;  s = s + term;
      term = ((term * t2) >>> 30) / 42;  s = s - term;
      term = ((term * t2) >>> 30) / 72;  s = s + term;
      term = ((term * t2) >>> 30) / 110; s = s - term;
      term = ((term * t2) >>> 30) / 156; s = s + term;
      c = 64'sd1073741824;
      term = c;
      term = ((term * t2) >>> 30) / 2;   c = c - term;
      term = ((term * t2) >>> 30) / 12;  c = c + term;
      term = ((term * t2) >>> 30) / 30;  c = c - term;
      term = ((term * t2) >>> 30) / 56;  c = c + term;
      term = ((term * t2) >>> 30) / 90;  c = c - term;
      term = ((term * t2) >>> 30) / 132; c = c + term;
      if (s < 0) s = 0;
      if (s > 64'sd1073741824) s = 64'sd1073741824;
      if (c < 0) c = 0;
      if (c > 64'sd1073741824) c = 64'sd1073741824;
      s = (s + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      c = (c + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      tab[r] = want_sin ? TRIG_W'(s) : TRIG_W'(c);
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig(1'b1);
  localparam trig_tab_t COS_TAB = build_trig(1'b0);

endpackage

@@ hdl/fgn_datapath.sv @@
// Octave datapath of the fractal noise block: scaling, corner hash, gradient,
// dot products, smootherstep blend, octave sum and restoring divider.
// Depends on fgn_pkg.
`timescale 1ns / 1ps

module fgn_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  fgn_pkg::dp_cmd_t                cmd,
  output fgn_pkg::dp_status_t             status,
  input  logic signed [fgn_pkg::COORD_W-1:0] coord_x,
  input  logic signed [fgn_pkg::COORD_W-1:0] coord_y,
  input  logic [fgn_pkg::PERS_W-1:0]      persistence,
  input  logic [fgn_pkg::FREQ_W-1:0]      base_frequency,
  output logic [fgn_pkg::NOISE_W-1:0]     noise_value
);
  import fgn_pkg::*;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic signed [FADE_W-1:0] FADE_15 = FADE_W'(15 << FRAC_BITS);
  localparam logic signed [FADE_W-1:0] FADE_10 = FADE_W'(10 << FRAC_BITS);
  localparam logic signed [GRAD_W-1:0] ONE_G   = GRAD_W'(1 << FRAC_BITS);
  localparam logic signed [FADE_W:0]   ONE_V   = (FADE_W+1)'(1 << FRAC_BITS);
  localparam logic [QUO_W-1:0]         ONE_N   = QUO_W'(1 << FRAC_BITS);
  localparam logic [AMP_W-1:0]         AMP_ONE = AMP_W'(1 << 15);
  localparam logic [NOISE_W-1:0]       NOISE_MAX = '1;

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic signed [FADE_W-1:0] fade_first(input logic [FRAC_BITS-1:0] w);
    logic signed [FADE_W-1:0]   ws, u1;
    logic signed [2*FADE_W-1:0] p;
    ws = $signed({{(FADE_W-FRAC_BITS){1'b0}}, w});
    u1 = (ws <<< 2) + (ws <<< 1) - FADE_15;
    p  = ws * u1;
    return FADE_W'(p >>> FRAC_BITS) + FADE_10;
  endfunction

  function automatic logic signed [FADE_W-1:0] fade_mul(input logic signed [FADE_W-1:0] u,
                                                        input logic [FRAC_BITS-1:0] w);
    logic signed [FADE_W-1:0]   ws;
    logic signed [2*FADE_W-1:0] p;
    ws = $signed({{(FADE_W-FRAC_BITS){1'b0}}, w});
    p  = u * ws;
    return FADE_W'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [FADE_W-1:0] blend(input logic signed [FADE_W-1:0] a0,
                                                     input logic signed [FADE_W-1:0] a1,
                                                     input logic signed [FADE_W-1:0] s);
    logic signed [FADE_W:0]     diff;
    logic signed [2*FADE_W:0]   p;
    diff = (FADE_W+1)'(a1) - (FADE_W+1)'(a0);
    p    = diff * s;
    return a0 + FADE_W'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [PROD_W-1:0] coord_mul(input logic signed [COORD_W-1:0] c);
    logic signed [PROD_W-1:0] p;
    p = c * $signed({1'b0, base_frequency});
    return p;
  endfunction

  logic signed [COORD_W-1:0]   cx, cy;
  logic [31:0]                 x0, y0, x1, y1;
  logic [FRAC_BITS-1:0]        fx, fy;
  logic [31:0]                 ax [2];
  logic [31:0]                 bh [4];
  logic [31:0]                 hh [4];
  logic signed [GRAD_W-1:0]    gx [4];
  logic signed [GRAD_W-1:0]    gy [4];
  logic signed [DOT_W-1:0]     dot [4];
  logic signed [FADE_W-1:0]    fu_x, fu_y, e0, e1, v;
  logic [AMP_W-1:0]            amp;
  logic [ASUM_W-1:0]           amp_sum;
  logic [TOT_W-1:0]            total, rem, dsh;
  logic [QUO_W-1:0]            quo;
  logic [DIV_CNT_W-1:0]        div_cnt;

  logic signed [PROD_W-1:0]    prod_x, prod_y, sh_x, sh_y;
  logic [31:0]                 bh_next [4];
  logic [31:0]                 hh_next [4];
  logic signed [GRAD_W-1:0]    gx_next [4];
  logic signed [GRAD_W-1:0]    gy_next [4];
  logic signed [DOT_W-1:0]     dot_next [4];
  logic signed [FADE_W:0]      v_off, n_half;
  logic [QUO_W-1:0]            n_val;
  logic [QUO_W+AMP_W-1:0]      n_amp;
  logic [AMP_W+PERS_W-1:0]     amp_prod;
  logic                        div_ge;

  // Scale the point by base_frequency * 2^octave, floored to FRAC_BITS.
  always_comb begin
    prod_x = coord_mul(cx);
    prod_y = coord_mul(cy);
    sh_x   = prod_x >>> (SCALE_SHIFT - int'(cmd.octave));
    sh_y   = prod_y >>> (SCALE_SHIFT - int'(cmd.octave));
  end

  assign x1 = x0 + 32'd1;
  assign y1 = y0 + 32'd1;

  // Corner k: bit 0 picks x1 over x0, bit 1 picks y1 over y0.
  always_comb begin
    logic [TAB_W-1:0]         r;
    logic signed [GRAD_W-1:0] sn, cs, dx, dy;
    logic signed [2*GRAD_W:0] pd;
    for (int k = 0; k < 4; k++) begin
      bh_next[k] = ((k[1] ? y1 : y0) ^ rot16(ax[k[0]])) * HASH_C2;
      hh_next[k] = (ax[k[0]] ^ rot16(bh[k])) * HASH_C3;

      r  = hh[k][32-ANGLE_BITS +: TAB_W];
      sn = $signed({1'b0, SIN_TAB[r]});
      cs = $signed({1'b0, COS_TAB[r]});
      case (hh[k][31 -: 2])
        QUAD_0: begin gx_next[k] = cs;  gy_next[k] = sn;  end
        QUAD_1: begin gx_next[k] = -sn; gy_next[k] = cs;  end
        QUAD_2: begin gx_next[k] = -cs; gy_next[k] = -sn; end
        QUAD_3: begin gx_next[k] = sn;  gy_next[k] = -cs; end
        default: begin gx_next[k] = cs; gy_next[k] = sn;  end
      endcase

      dx = $signed({2'b00, fx}) - (k[0] ? ONE_G : '0);
      dy = $signed({2'b00, fy}) - (k[1] ? ONE_G : '0);
      pd = dx * gx[k] + dy * gy[k];
      dot_next[k] = DOT_W'(pd >>> FRAC_BITS);
    end
  end

  // Map the octave value from [-1,1] to [0,1] and clamp.
  always_comb begin
    v_off  = (FADE_W+1)'(v) + ONE_V;
    n_half = v_off >>> 1;
    if (n_half < 0) begin
      n_val = '0;
    end else if (n_half > $signed({1'b0, ONE_V[FADE_W-1:0]})) begin
      n_val = ONE_N;
    end else begin
      n_val = QUO_W'(n_half);
    end
    n_amp    = n_val * amp;
    amp_prod = amp * persistence + (AMP_W+PERS_W)'(1 << 14);
    div_ge   = rem >= dsh;
  end

  assign status.div_last = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt     <= '0;
      noise_value <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          cx      <= coord_x;
          cy      <= coord_y;
          total   <= '0;
          amp_sum <= '0;
          amp     <= AMP_ONE;
        end
        OP_SCALE: begin
          x0 <= sh_x[FRAC_BITS +: 32];
          y0 <= sh_y[FRAC_BITS +: 32];
          fx <= sh_x[FRAC_BITS-1:0];
          fy <= sh_y[FRAC_BITS-1:0];
        end
        OP_HASH1: begin
          ax[0] <= x0 * HASH_C1;
          ax[1] <= x1 * HASH_C1;
          fu_x  <= fade_first(fx);
          fu_y  <= fade_first(fy);
        end
        OP_HASH2: begin
          bh   <= bh_next;
          fu_x <= fade_mul(fu_x, fx);
          fu_y <= fade_mul(fu_y, fy);
        end
        OP_HASH3: begin
          hh   <= hh_next;
          fu_x <= fade_mul(fu_x, fx);
          fu_y <= fade_mul(fu_y, fy);
        end
        OP_GRAD: begin
          gx   <= gx_next;
          gy   <= gy_next;
          fu_x <= fade_mul(fu_x, fx);
          fu_y <= fade_mul(fu_y, fy);
        end
        OP_DOT: begin
          dot <= dot_next;
        end
        OP_BLEND1: begin
          e0 <= blend(FADE_W'(dot[0]), FADE_W'(dot[1]), fu_x);
          e1 <= blend(FADE_W'(dot[2]), FADE_W'(dot[3]), fu_x);
        end
        OP_BLEND2: begin
          v <= blend(e0, e1, fu_y);
        end
        OP_ACCUM: begin
          total   <= total + TOT_W'(n_amp);
          amp_sum <= amp_sum + ASUM_W'(amp);
          amp     <= AMP_W'(amp_prod >> 15);
        end
        OP_DIV_INIT: begin
          rem     <= total;
          dsh     <= TOT_W'(amp_sum) << FRAC_BITS;
          quo     <= '0;
          div_cnt <= DIV_CNT_W'(QUO_W - 1);
        end
        OP_DIV_STEP: begin
          if (div_ge) begin
            rem <= rem - dsh;
          end
          dsh     <= dsh >> 1;
          quo     <= {quo[QUO_W-2:0], div_ge};
          div_cnt <= div_cnt - DIV_CNT_W'(1);
        end
        OP_OUT: begin
          noise_value <= quo[QUO_W-1] ? NOISE_MAX : quo[NOISE_W-1:0];
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/fgn_ctrl.sv @@
// Controller of the fractal noise block: sequences the octave steps and the
// divider, and owns the input stall and the output valid. Depends on fgn_pkg and fractal_gradient_noise_2d_defines.svh.
`timescale 1ns / 1ps
`include "fractal_gradient_noise_2d_defines.svh"

module fgn_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  input  logic [fgn_pkg::CNT_W-1:0]  octave_count_eff,
  output fgn_pkg::dp_cmd_t           cmd,
  input  fgn_pkg::dp_status_t        status
);
  import fgn_pkg::*;

  state_t           state, state_next;
  logic [OCT_W-1:0] octave;
  logic             in_accept, slot_free, last_oct;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign last_oct  = (CNT_W'(octave) == octave_count_eff - CNT_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) begin state_next = ST_SCALE; end
      ST_SCALE:    state_next = ST_HASH1;
      ST_HASH1:    state_next = ST_HASH2;
      ST_HASH2:    state_next = ST_HASH3;
      ST_HASH3:    state_next = ST_GRAD;
      ST_GRAD:     state_next = ST_DOT;
      ST_DOT:      state_next = ST_BLEND1;
      ST_BLEND1:   state_next = ST_BLEND2;
      ST_BLEND2:   state_next = ST_ACCUM;
      ST_ACCUM:    state_next = last_oct ? ST_DIV_INIT : ST_SCALE;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV:      if (status.div_last) begin state_next = ST_DONE; end
      ST_DONE:     if (slot_free) begin state_next = ST_IDLE; end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.octave = octave;
    unique case (state)
      ST_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_IDLE;
      ST_SCALE:    cmd.op = OP_SCALE;
      ST_HASH1:    cmd.op = OP_HASH1;
      ST_HASH2:    cmd.op = OP_HASH2;
      ST_HASH3:    cmd.op = OP_HASH3;
      ST_GRAD:     cmd.op = OP_GRAD;
      ST_DOT:      cmd.op = OP_DOT;
      ST_BLEND1:   cmd.op = OP_BLEND1;
      ST_BLEND2:   cmd.op = OP_BLEND2;
      ST_ACCUM:    cmd.op = OP_ACCUM;
      ST_DIV_INIT: cmd.op = OP_DIV_INIT;
      ST_DIV:      cmd.op = OP_DIV_STEP;
      ST_DONE:     cmd.op = slot_free ? OP_OUT : OP_IDLE;
      default:     cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      octave    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == OP_LOAD) begin
        octave <= '0;
      end else if (cmd.op == OP_ACCUM && !last_oct) begin
        octave <= octave + OCT_W'(1);
      end
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FGN_ASSERT_NEXT(a_accept_starts, clk, rst, in_accept, state == ST_SCALE)
  `FGN_ASSERT_SAME(a_out_slot_free, clk, rst, cmd.op == OP_OUT, !out_valid || !out_stall)
  `FGN_ASSERT_SAME(a_octave_range, clk, rst, state != ST_IDLE,
                   CNT_W'(octave) < octave_count_eff)
  `FGN_ASSERT_NEXT(a_div_done, clk, rst, state == ST_DIV && status.div_last,
                   state == ST_DONE && out_valid == $past(out_valid && out_stall))

endmodule

@@ hdl/fractal_gradient_noise_2d.sv @@
// Fractal 2-D gradient noise, top level: configuration registers, controller
// and octave datapath. Depends on fgn_pkg, fgn_ctrl and fgn_datapath.
`timescale 1ns / 1ps

// Takes one signed Q16.16 point (coord_x, coord_y) per request and returns
// fractal gradient noise as unsigned Q0.16 in noise_value. One request is in
// flight at a time: each octave steps through the shared octave datapath
// (scale, three hash multiplies, gradient lookup, dot products, two blends,
// accumulate), and the final normalization is a restoring divider that
// yields one quotient bit per cycle. Once the result is loaded into the
// output register the block is idle and the next request can be accepted;
// the output register lets the next request be accepted while that result
// still waits on out_stall.
// octave_count of zero runs one octave, values above eight run eight.
// Configuration writes (cfg_index 0..2) are always ready and must be issued
// only while the block is idle; other indexes are ignored.

module fractal_gradient_noise_2d (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [fgn_pkg::COORD_W-1:0] coord_x,
  input  logic signed [fgn_pkg::COORD_W-1:0] coord_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fgn_pkg::NOISE_W-1:0]        noise_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fgn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fgn_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fgn_pkg::*;

  logic [CNT_W-1:0]  octave_count;
  logic [PERS_W-1:0] persistence;
  logic [FREQ_W-1:0] base_frequency;
  logic [CNT_W-1:0]  octave_count_eff;
  dp_cmd_t           cmd;
  dp_status_t        status;

  // Writes are always accepted: cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count   <= OCTAVE_COUNT_RST;
      persistence    <= PERSISTENCE_RST;
      base_frequency <= BASE_FREQUENCY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OCTAVE_COUNT:   octave_count   <= cfg_data[CNT_W-1:0];
        CFG_PERSISTENCE:    persistence    <= cfg_data[PERS_W-1:0];
        CFG_BASE_FREQUENCY: base_frequency <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the octave count into 1..MAX_OCTAVES.
  always_comb begin
    if (octave_count == '0) begin
      octave_count_eff = CNT_W'(1);
    end else if (octave_count > CNT_W'(MAX_OCTAVES)) begin
      octave_count_eff = CNT_W'(MAX_OCTAVES);
    end else begin
      octave_count_eff = octave_count;
    end
  end

  fgn_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .octave_count_eff (octave_count_eff),
    .cmd              (cmd),
    .status           (status)
  );

  fgn_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .persistence    (persistence),
    .base_frequency (base_frequency),
    .noise_value    (noise_value)
  );

endmodule
